>>> rtl/fldc_pkg.sv
// Shared types, sizes and coefficients for the delay-compensated low-pass FIR.
package fldc_pkg;

  localparam int TAPS        = 13;
  localparam int DELAY       = 6;
  localparam int SAMPLE_BITS = 16;
  localparam int LINE_LEN    = TAPS - 1;

  localparam int COEF_W  = 17;
  localparam int PROD_W  = SAMPLE_BITS + COEF_W;
  localparam int ACC_W   = PROD_W + $clog2(TAPS) + 1;
  localparam int FRAC_DROP = 15;
  localparam int Q_W     = ACC_W - FRAC_DROP;
  localparam int OUT_W   = 20;

  localparam int SEEN_W  = (DELAY > 0) ? $clog2(DELAY + 1) : 1;
  localparam int FLUSH_W = (DELAY > 1) ? $clog2(DELAY) : 1;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_DROP - 1);
  localparam logic signed [Q_W-1:0]   Q_MAX = Q_W'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [Q_W-1:0]   Q_MIN = -Q_W'(1 << (OUT_W - 1));

  // Q1.15 coefficients; index 0 weights the newest sample
  localparam logic signed [COEF_W-1:0] COEF [TAPS] = '{
    17'sd1845,  17'sd4865,  17'sd10058, 17'sd17255, 17'sd25703,
    17'sd33882, 17'sd39728, 17'sd41155, 17'sd36650, 17'sd25929,
    17'sd10318, -17'sd7323, -17'sd23245
  };

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
  } item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] filtered;
    logic                    block_end;
  } result_t;

endpackage

>>> rtl/fldc_cell.sv
// One tap of the transposed FIR: constant multiply plus partial-sum register.
module fldc_cell (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 step,
  input  logic                                 clear,
  input  logic signed [fldc_pkg::SAMPLE_BITS-1:0] x,
  input  logic signed [fldc_pkg::COEF_W-1:0]   coef,
  input  logic signed [fldc_pkg::ACC_W-1:0]    sum_in,
  output logic signed [fldc_pkg::ACC_W-1:0]    sum_out
);
  import fldc_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  sum_next;

  assign prod = x * coef;

  always_comb begin
    sum_next = sum_out;
    if (step) begin
      if (clear) begin
        sum_next = '0;
      end else begin
        sum_next = ACC_W'(prod) + sum_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_out <= '0;
    end else begin
      sum_out <= sum_next;
    end
  end

endmodule

>>> rtl/fldc_outq.sv
// Two-word result queue between the tap chain and the result port.
module fldc_outq (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  fldc_pkg::result_t   din,
  output logic                space,
  output logic                result_valid,
  input  logic                result_ready,
  output fldc_pkg::result_t   result
);
  import fldc_pkg::*;

  result_t     mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        pop;

  assign space        = (count != 2'd2);
  assign result_valid = (count != 2'd0);
  assign result       = mem[rd_ptr];
  assign pop          = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/fir_lowpass_delay_compensated.sv
// Top level: block-framed 13-tap low-pass FIR with 6-sample delay compensation.
//
//   port group     dir   payload     handshake
//   item           in    item_t      item_valid / item_ready
//   result         out   result_t    result_valid / result_ready
//
// One sample word enters per cycle while item_ready is high; each pushes through
// the transposed tap chain. The word marked last is followed by a flush of 6 zero
// samples, during which item_ready is low; then the chain and sample counter are
// cleared. A two-word result queue holds stalled results; input also stalls when
// it is full. Synchronous active-high rst clears the chain, counters and queue.
module fir_lowpass_delay_compensated (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  fldc_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output fldc_pkg::result_t result
);
  import fldc_pkg::*;

  logic                          flushing;
  logic [FLUSH_W-1:0]            flush_cnt;
  logic [SEEN_W-1:0]             seen;
  logic                          space;
  logic                          push;
  logic                          produce;
  logic                          end_push;
  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [ACC_W-1:0]       chain [TAPS];
  logic signed [PROD_W-1:0]      prod0;
  logic signed [ACC_W-1:0]       acc;
  logic signed [ACC_W-1:0]       rnd;
  logic signed [Q_W-1:0]         q;
  result_t                       res_word;

  assign item_ready = !flushing && space;
  assign push       = flushing ? space : (item_valid && item_ready);
  assign x          = flushing ? '0 : item.sample;
  assign produce    = (seen == SEEN_W'(DELAY));
  // final push of a block: last flush step, or the last word itself with no delay
  assign end_push   = flushing ? (flush_cnt == FLUSH_W'(DELAY - 1))
                               : (item.last && (DELAY == 0));

  assign chain[LINE_LEN] = '0;

  for (genvar k = 1; k < TAPS; k++) begin : g_tap
    fldc_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .step    (push),
      .clear   (end_push),
      .x       (x),
      .coef    (COEF[k]),
      .sum_in  (chain[k]),
      .sum_out (chain[k-1])
    );
  end

  assign prod0 = x * COEF[0];
  assign acc   = ACC_W'(prod0) + chain[0];
  assign rnd   = acc + ROUND_HALF;
  assign q     = rnd[ACC_W-1:FRAC_DROP];

  always_comb begin
    res_word.block_end = end_push;
    if (q > Q_MAX) begin
      res_word.filtered = OUT_W'(Q_MAX);
    end else if (q < Q_MIN) begin
      res_word.filtered = OUT_W'(Q_MIN);
    end else begin
      res_word.filtered = q[OUT_W-1:0];
    end
  end

  fldc_outq u_outq (
    .clk          (clk),
    .rst          (rst),
    .push         (push && produce),
    .din          (res_word),
    .space        (space),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      flushing  <= 1'b0;
      flush_cnt <= '0;
      seen      <= '0;
    end else if (push) begin
      if (end_push) begin
        seen <= '0;
      end else if (!produce) begin
        seen <= seen + SEEN_W'(1);
      end
      if (flushing) begin
        if (end_push) begin
          flushing <= 1'b0;
        end else begin
          flush_cnt <= flush_cnt + FLUSH_W'(1);
        end
      end else if (item.last && (DELAY != 0)) begin
        flushing  <= 1'b1;
        flush_cnt <= '0;
      end
    end
  end

endmodule
